// ===== hw/rtl/nbse_pkg.sv =====
`default_nettype none
// ============================================================================
// nbse_pkg
// Shared types and field widths of the NFA bit-set step engine.
// ============================================================================
package nbse_pkg;

    // Field widths of one request and one result
    localparam int CMD_W    = 2;
    localparam int STATE_FW = 4;
    localparam int SYM_FW   = 4;
    localparam int ROW_FW   = 16;
    localparam int SET_FW   = 16;

    // Request stream: cmd in tuser, the other fields packed in tdata
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    typedef logic [STATE_FW-1:0] t_state_idx;
    typedef logic [SYM_FW-1:0]   t_sym_idx;
    typedef logic [ROW_FW-1:0]   t_row_field;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_TRANS  = 2'd0,
        CMD_LOAD_CLOS  = 2'd1,
        CMD_RESTART    = 2'd2,
        CMD_CONSUME    = 2'd3
    } t_cmd;

endpackage : nbse_pkg
`default_nettype wire

// ===== hw/rtl/nfa_bitset_step_engine.sv =====
`default_nettype none
// ============================================================================
// nfa_bitset_step_engine
// Bit-vector NFA simulation with software-computed lambda-closure rows.
// ============================================================================
//
// Each request on the slave stream is one command: add a transition bit,
// load a closure row, restart from the initial mask, or consume a symbol.
// Every request returns one result on the master stream: the active set
// after the command and a flag that is high when the set is empty.
// One request is taken every cycle when the output side keeps up. A request
// taken sits in the request register, and its result is then loaded into the
// result register. A stalled result holds the request register, and input is
// then held off until the result leaves.
// The two-stage timing comes from one read of the transition memory per
// request: the memory is indexed by symbol and one entry holds the whole
// NUM_STATES x NUM_STATES transition matrix of that symbol, so a consume
// needs a single read followed by two OR reductions (transition rows of the
// active states, then closure rows of the new states).
// Table writes (add transition, load closure row) land at the edge that
// takes the request, so the very next request already sees them. The
// transition memory starts empty through one valid bit per symbol entry;
// there is no clearing pass. initial_mask is written through i_cfg_wr_en /
// i_cfg_wr_data and must only change while the engine is idle.
//
module nfa_bitset_step_engine
    import nbse_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // initial_mask register
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [SET_FW-1:0]    i_cfg_wr_data,

    // request stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [3:0] from_state, [7:4] symbol, [11:8] to_state, [27:12] row_bits
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  wire logic [CMD_W-1:0]     s_axis_tuser,

    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [15:0] active_set
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // [0] set_empty
    output logic                      m_axis_tuser
);

    localparam int SYM_AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int ST_AW  = $clog2(NUM_STATES);

    typedef logic [NUM_STATES-1:0]                  t_set;
    typedef logic [NUM_STATES-1:0][NUM_STATES-1:0]  t_matrix;

    // ---------------------------------------------------------------- fields
    t_cmd        w_cmd;
    t_state_idx  w_from;
    t_sym_idx    w_sym;
    t_state_idx  w_to;
    t_row_field  w_row;

    assign w_cmd  = t_cmd'(s_axis_tuser);
    assign w_from = s_axis_tdata[3:0];
    assign w_sym  = s_axis_tdata[7:4];
    assign w_to   = s_axis_tdata[11:8];
    assign w_row  = s_axis_tdata[27:12];

    // --------------------------------------------------------------- storage
    t_matrix             r_tmem [NUM_SYMBOLS];   // per symbol: [from][to]
    logic [NUM_SYMBOLS-1:0] r_tvalid;            // entry written since reset
    t_set                r_clos [NUM_STATES];    // lambda-closure rows
    t_set                r_init;                 // initial_mask
    t_set                r_active;               // current active set

    // request register (stage 1)
    logic    r_s1_valid;
    t_cmd    r_s1_cmd;
    logic    r_s1_hit;                           // symbol in range, entry valid
    t_matrix r_s1_trow;                          // transition matrix read

    // result register
    logic              r_out_valid;
    logic [SET_FW-1:0] r_out_set;
    logic              r_out_empty;

    // --------------------------------------------------------------- control
    logic w_out_adv;     // result register may load
    logic w_in_acc;      // request taken this edge
    logic w_sym_ok;
    logic w_from_ok;
    logic w_to_ok;
    logic w_add_we;
    logic w_clos_we;
    logic [SYM_AW-1:0] w_addr;
    logic [ST_AW-1:0]  w_clos_addr;
    logic w_entry_valid;
    t_matrix w_onehot;

    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || w_out_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_sym_ok  = int'(w_sym)  < NUM_SYMBOLS;
    assign w_from_ok = int'(w_from) < NUM_STATES;
    assign w_to_ok   = int'(w_to)   < NUM_STATES;
    assign w_addr    = SYM_AW'(w_sym);
    assign w_clos_addr   = ST_AW'(w_from);
    assign w_entry_valid = w_sym_ok && r_tvalid[w_addr];

    assign w_add_we  = w_in_acc && (w_cmd == CMD_ADD_TRANS)
                       && w_sym_ok && w_from_ok && w_to_ok;
    assign w_clos_we = w_in_acc && (w_cmd == CMD_LOAD_CLOS) && w_from_ok;

    // single set bit at [from][to]
    always_comb begin
        for (int f = 0; f < NUM_STATES; f++) begin
            for (int t = 0; t < NUM_STATES; t++) begin
                w_onehot[f][t] = (int'(w_from) == f) && (int'(w_to) == t);
            end
        end
    end

    // ------------------------------------------------------ transition memory
    // Bit-masked write: an entry's first write fills the whole matrix so
    // stale contents never show; later writes touch only the new bit.
    always_ff @(posedge i_clk) begin
        if (w_add_we) begin
            for (int f = 0; f < NUM_STATES; f++) begin
                for (int t = 0; t < NUM_STATES; t++) begin
                    if (!r_tvalid[w_addr] || w_onehot[f][t]) begin
                        r_tmem[w_addr][f][t] <= w_onehot[f][t];
                    end
                end
            end
        end
        if (w_in_acc) begin
            r_s1_trow <= r_tmem[w_addr];
        end
    end

    // -------------------------------------------------- tables and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
            for (int s = 0; s < NUM_STATES; s++) begin
                r_clos[s] <= '0;
            end
            r_init <= t_set'(1);
        end else begin
            if (w_add_we) begin
                r_tvalid[w_addr] <= 1'b1;
            end
            if (w_clos_we) begin
                r_clos[w_clos_addr] <= t_set'(w_row);
            end
            if (i_cfg_wr_en) begin
                r_init <= t_set'(i_cfg_wr_data);
            end
        end
    end

    // ----------------------------------------------------- set update logic
    t_set w_base;
    t_set w_next;

    always_comb begin
        w_base = '0;
        case (r_s1_cmd)
            CMD_RESTART: begin
                w_base = r_init;
            end
            CMD_CONSUME: begin
                // union of transition rows of the active states
                for (int s = 0; s < NUM_STATES; s++) begin
                    if (r_active[s] && r_s1_hit) begin
                        w_base = w_base | r_s1_trow[s];
                    end
                end
            end
            default: begin
                w_base = '0;
            end
        endcase

        w_next = r_active;
        if (r_s1_cmd == CMD_RESTART || r_s1_cmd == CMD_CONSUME) begin
            // closure rows are already transitive: one pass suffices
            w_next = w_base;
            for (int s = 0; s < NUM_STATES; s++) begin
                if (w_base[s]) begin
                    w_next = w_next | r_clos[s];
                end
            end
        end
    end

    // ------------------------------------------------------ pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= '0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_active <= w_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cmd <= w_cmd;
            r_s1_hit <= w_entry_valid;
        end
        if (w_out_adv && r_s1_valid) begin
            r_out_set   <= SET_FW'(w_next);
            r_out_empty <= (w_next == '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_set;
    assign m_axis_tuser  = r_out_empty;

    // ------------------------------------------------------------ assertions
    // a request waiting behind a stalled result is not dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_out_adv |=> r_s1_valid)
        else $error("stage-1 request lost while output stalled");

    // the result register mirrors the active set it was loaded with
    a_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_adv && r_s1_valid |=> m_axis_tdata == SET_FW'(r_active))
        else $error("result does not match active set");

    // a restart always leaves every initial state active
    a_restart_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_adv && r_s1_valid && r_s1_cmd == CMD_RESTART
        |=> (r_active & $past(r_init)) == $past(r_init))
        else $error("restart dropped an initial state");

endmodule : nfa_bitset_step_engine
`default_nettype wire

// ===== tb/sv/tb_nfa_bitset_step_engine.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_nfa_bitset_step_engine
// Self-checking bench for the bit-vector NFA step engine.
// ============================================================================
//
// Requests go in on the slave stream and results come back on the master
// stream. The bench keeps its own copy of the transition table, the closure
// table, the active set and initial_mask, and it updates that copy at every
// request handshake. Each result is then compared with the oldest
// expectation, field by field.
// A directed table comes first. After that come random phases with
// different idle patterns and initial_mask settings. The last phase stops
// the receiver for a long stretch so that the engine fills up and
// backpressures its input.
//
module tb_nfa_bitset_step_engine;
    import nbse_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RST_CYCLES      = 6;
    localparam int N_ST            = 16;
    localparam int N_SYM           = 16;
    localparam int N_PHASES        = 5;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES    = 6;
    localparam int MAX_REPORTS     = 10;
    localparam int N_DIRECTED      = 20;

    // ------------------------------------------------------------------------
    // DUT inputs, all driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [SET_FW-1:0]    i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [3:0] from_state, [7:4] symbol, [11:8] to_state, [27:12] row_bits
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // [1:0] cmd
    logic [CMD_W-1:0]     s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [15:0] active_set
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] set_empty
    logic                 m_axis_tuser;

    always #CLK_HALF i_clk = ~i_clk;

    nfa_bitset_step_engine #(
        .NUM_STATES  (N_ST),
        .NUM_SYMBOLS (N_SYM)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // Expected results and the bench's copy of the automaton
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [SET_FW-1:0] active_set;
        logic              set_empty;
    } t_nfa_result;

    t_nfa_result       pending_sets [$];   // oldest expectation at the front

    logic [N_ST-1:0]   trans_tbl [N_ST][N_SYM];  // [from][symbol] -> to bits
    logic [N_ST-1:0]   lambda_tbl [N_ST];        // closure row per state
    logic [N_ST-1:0]   live_set   = '0;
    logic [SET_FW-1:0] start_mask = 16'h0001;    // initial_mask after reset

    int mismatches   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;

    // Directed row: request fields, plus a hand-typed result where it is obvious
    typedef struct packed {
        t_cmd              cmd;
        t_state_idx        from_s;
        t_sym_idx          sym;
        t_state_idx        to_s;
        t_row_field        row;
        logic              known;
        logic [SET_FW-1:0] want;
    } t_dir_row;

    // Mask 1, empty tables after reset. Unused fields carry junk on purpose.
    localparam t_dir_row DIR_ROWS [N_DIRECTED] = '{
        // add 0 -(0)-> 1 right after reset: nothing active yet
        '{CMD_ADD_TRANS, 4'd0,  4'd0,  4'd1,  16'hFFFF, 1'b1, 16'h0000},
        '{CMD_RESTART,   4'd15, 4'd15, 4'd15, 16'hA5A5, 1'b1, 16'h0001},
        '{CMD_CONSUME,   4'd9,  4'd0,  4'd6,  16'h5A5A, 1'b1, 16'h0002},
        // no edge on symbol 5: run dies
        '{CMD_CONSUME,   4'd0,  4'd5,  4'd0,  16'h0000, 1'b1, 16'h0000},
        '{CMD_RESTART,   4'd0,  4'd0,  4'd0,  16'h0000, 1'b1, 16'h0001},
        '{CMD_ADD_TRANS, 4'd15, 4'd15, 4'd15, 16'h0000, 1'b1, 16'h0001},
        // duplicate edge, no change
        '{CMD_ADD_TRANS, 4'd0,  4'd0,  4'd1,  16'h1234, 1'b1, 16'h0001},
        '{CMD_ADD_TRANS, 4'd1,  4'd15, 4'd15, 16'h0000, 1'b1, 16'h0001},
        '{CMD_LOAD_CLOS, 4'd1,  4'd7,  4'd3,  16'hFFFF, 1'b1, 16'h0001},
        '{CMD_LOAD_CLOS, 4'd15, 4'd0,  4'd0,  16'h8001, 1'b1, 16'h0001},
        // 0 -> 1, then closure of 1 is everything
        '{CMD_CONSUME,   4'd0,  4'd0,  4'd0,  16'h0000, 1'b1, 16'hFFFF},
        '{CMD_CONSUME,   4'd4,  4'd15, 4'd8,  16'hFFFF, 1'b0, 16'h0000},
        '{CMD_LOAD_CLOS, 4'd0,  4'd3,  4'd3,  16'hFFFF, 1'b0, 16'h0000},
        '{CMD_RESTART,   4'd0,  4'd0,  4'd0,  16'h0000, 1'b1, 16'hFFFF},
        '{CMD_LOAD_CLOS, 4'd0,  4'd15, 4'd15, 16'h0000, 1'b0, 16'h0000},
        '{CMD_LOAD_CLOS, 4'd1,  4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000},
        '{CMD_CONSUME,   4'd15, 4'd0,  4'd15, 16'hFFFF, 1'b0, 16'h0000},
        '{CMD_CONSUME,   4'd0,  4'd15, 4'd0,  16'h0000, 1'b0, 16'h0000},
        '{CMD_CONSUME,   4'd0,  4'd7,  4'd0,  16'h0000, 1'b1, 16'h0000},
        // dead run stays dead
        '{CMD_CONSUME,   4'd0,  4'd0,  4'd0,  16'h0000, 1'b1, 16'h0000}
    };

    // ------------------------------------------------------------------------
    // Automaton copy
    // ------------------------------------------------------------------------
    // Closure rows are taken as already transitive: one pass is enough.
    function automatic logic [N_ST-1:0] close_over(input logic [N_ST-1:0] seed);
        logic [N_ST-1:0] acc;
        acc = seed;
        for (int s = 0; s < N_ST; s++)
            if (seed[s]) acc |= lambda_tbl[s];
        return acc;
    endfunction

    function automatic void step_nfa(input t_cmd cmd, input t_state_idx from_s,
                                     input t_sym_idx sym, input t_state_idx to_s,
                                     input t_row_field row);
        logic [N_ST-1:0] nxt;
        nxt = '0;
        case (cmd)
            CMD_ADD_TRANS: trans_tbl[from_s][sym][to_s] = 1'b1;
            CMD_LOAD_CLOS: lambda_tbl[from_s] = row;
            CMD_RESTART:   live_set = close_over(start_mask);
            default: begin
                for (int s = 0; s < N_ST; s++)
                    if (live_set[s]) nxt |= trans_tbl[s][sym];
                live_set = close_over(nxt);
            end
        endcase
    endfunction

    function automatic void flag_mismatch(input string what,
                                          input logic [SET_FW-1:0] want,
                                          input logic [SET_FW-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Idle cycles first (junk on the bus), then hold the request until taken.
    // The expectation is pushed at the accepting edge.
    task automatic send_request(input t_cmd cmd, input t_state_idx from_s,
                                input t_sym_idx sym, input t_state_idx to_s,
                                input t_row_field row, input logic known,
                                input logic [SET_FW-1:0] want);
        t_nfa_result res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= CMD_W'($urandom_range(3));
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'h0, row, to_s, sym, from_s};
        do @(posedge i_clk); while (!s_axis_tready);
        step_nfa(cmd, from_s, sym, to_s, row);
        res.active_set = known ? want : live_set;
        res.set_empty  = (res.active_set == '0);
        pending_sets.push_back(res);
    endtask

    // Mostly consume runs between restarts; adds grow the table slowly so
    // runs neither die at once nor saturate early.
    task automatic random_request();
        int         pick;
        t_cmd       cmd;
        t_row_field row;
        pick = $urandom_range(99);
        row  = ROW_FW'($urandom);
        if (pick < 20) begin
            cmd = CMD_ADD_TRANS;
        end else if (pick < 28) begin
            cmd = CMD_LOAD_CLOS;
            case ($urandom_range(3))
                0:       row = '0;
                1:       row = '1;
                default: row = ROW_FW'($urandom & $urandom & $urandom);
            endcase
        end else if (pick < 38) begin
            cmd = CMD_RESTART;
        end else begin
            cmd = CMD_CONSUME;
        end
        send_request(cmd, STATE_FW'($urandom), SYM_FW'($urandom),
                     STATE_FW'($urandom), row, 1'b0, '0);
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_sets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_mask(input logic [SET_FW-1:0] mask);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mask;
        @(posedge i_clk);
        start_mask = mask;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= ~mask;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus a counted hold-off when requested
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_nfa_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sets.size() == 0) begin
                flag_mismatch("unexpected result, active_set", '0, m_axis_tdata);
            end else begin
                exp_res = pending_sets.pop_front();
                if (m_axis_tdata !== exp_res.active_set)
                    flag_mismatch("active_set", exp_res.active_set, m_axis_tdata);
                if (m_axis_tuser !== exp_res.set_empty)
                    flag_mismatch("set_empty", SET_FW'(exp_res.set_empty),
                                  SET_FW'(m_axis_tuser));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [SET_FW-1:0] phase_mask [N_PHASES];
        int                phase_tx   [N_PHASES];
        int                phase_rx   [N_PHASES];

        // initial_mask: both extremes, a top bit alone, then random settings
        phase_mask = '{16'hFFFF, 16'h0000, 16'h8000,
                       SET_FW'($urandom), SET_FW'($urandom) | 16'h0001};
        // no idling, sender idle, receiver stalls, both light, hold-off
        phase_tx   = '{0, 70, 0, 7, 0};
        phase_rx   = '{0, 0, 70, 7, 0};

        for (int f = 0; f < N_ST; f++) begin
            lambda_tbl[f] = '0;
            for (int y = 0; y < N_SYM; y++) trans_tbl[f][y] = '0;
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset value of initial_mask
        foreach (DIR_ROWS[i])
            send_request(DIR_ROWS[i].cmd, DIR_ROWS[i].from_s, DIR_ROWS[i].sym,
                         DIR_ROWS[i].to_s, DIR_ROWS[i].row, DIR_ROWS[i].known,
                         DIR_ROWS[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            write_start_mask(phase_mask[ph]);
            tx_idle_pct  = phase_tx[ph];
            rx_stall_pct = phase_rx[ph];
            // last phase: receiver stops while the sender keeps pushing
            if (ph == N_PHASES - 1) rx_hold_left <= HOLD_CYCLES;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) random_request();
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/nbse_pkg.sv
hw/rtl/nfa_bitset_step_engine.sv
tb/sv/tb_nfa_bitset_step_engine.sv
